### hdl/vmpg_pkg.sv
// Package for the video mode pixel generator: payload structs, mode codes,
// the job descriptor passed between stages and the palette function.
// No dependencies.
`default_nettype none

package vmpg_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned X_W     = 9;
  localparam int unsigned CI_W    = 4;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned CA_W    = 16;
  localparam int unsigned FA_W    = 11;
  localparam int unsigned IDX_W   = 4;

  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADDR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RENDER = 2'd2;

  // mode select is mode_byte bits {7,1,0}
  localparam logic [2:0] MODE_LO    = 3'b000;
  localparam logic [2:0] MODE_MID   = 3'b001;
  localparam logic [2:0] MODE_TXT32 = 3'b010;
  localparam logic [2:0] MODE_HI    = 3'b011;
  localparam logic [2:0] MODE_TXT64 = 3'b110;

  localparam logic       REG_MODE   = 1'b0;
  localparam logic       REG_PERIOD = 1'b1;

  localparam logic [7:0]       MODE_RESET   = 8'h02;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 32'd200000;

  localparam logic [CI_W-1:0] CI_BLACK = 4'h0;
  localparam logic [CI_W-1:0] CI_WHITE = 4'hF;

  localparam logic [7:0] LVL_NORMAL = 8'd217;
  localparam logic [7:0] LVL_DIM    = 8'd38;
  localparam logic [7:0] LVL_FULL   = 8'hFF;
  localparam logic [7:0] LVL_OFF    = 8'h00;

  // last result index per job kind
  localparam logic [IDX_W-1:0] LAST_ADDR  = 4'd0;
  localparam logic [IDX_W-1:0] LAST_LO    = 4'd15;
  localparam logic [IDX_W-1:0] LAST_MID   = 4'd7;
  localparam logic [IDX_W-1:0] LAST_TXT32 = 4'd13;
  localparam logic [IDX_W-1:0] LAST_TXT64 = 4'd6;
  localparam logic [IDX_W-1:0] LAST_HI    = 4'd15;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [15:0]      tick_cycles;
    logic [7:0]       line;
    logic [5:0]       column;
    logic [7:0]       data_byte;
    logic [7:0]       attribute_byte;
    logic [7:0]       font_row;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0]   pixel_x;
    logic [CI_W-1:0]  color_index;
    logic [RGB_W-1:0] pixel_rgb;
    logic [CA_W-1:0]  cell_address;
    logic [FA_W-1:0]  font_address;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_ADDR,
    KIND_LO,
    KIND_MID,
    KIND_TXT32,
    KIND_TXT64,
    KIND_HI
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] last_idx;
    logic [X_W-1:0]   x_base;
    logic [7:0]       data_byte;
    logic [7:0]       font_row;
    logic             norm;
    logic [CI_W-1:0]  text_color;
    logic             inv;
    logic [CA_W-1:0]  cell_address;
    logic [FA_W-1:0]  font_address;
  } job_t;

  function automatic logic [7:0] palette_level(input logic bright, input logic on);
    logic [7:0] lvl;
    if (bright) begin
      lvl = on ? LVL_FULL : LVL_DIM;
    end else begin
      lvl = on ? LVL_NORMAL : LVL_OFF;
    end
    return lvl;
  endfunction

  // index bits are Y,B,G,R from msb to lsb
  function automatic logic [RGB_W-1:0] palette_rgb(input logic [CI_W-1:0] ci);
    return {palette_level(ci[3], ci[0]), palette_level(ci[3], ci[1]),
            palette_level(ci[3], ci[2])};
  endfunction

endpackage

`default_nettype wire

### hdl/vmpg_pixel.sv
// Result formatter: turns the current job and a result index into one
// result item. Depends on vmpg_pkg.
`default_nettype none

module vmpg_pixel
  import vmpg_pkg::*;
(
  input  job_t             job,
  input  logic [IDX_W-1:0] idx,
  output out_item_t        result
);

  logic [CI_W-1:0] ci;
  logic            bit_on;
  logic [CI_W-1:0] hi_nib;
  logic [CI_W-1:0] lo_nib;

  assign hi_nib = job.data_byte[7:4];
  assign lo_nib = job.data_byte[3:0];

  always_comb begin
    ci     = CI_BLACK;
    bit_on = 1'b0;
    case (job.kind)
      KIND_LO:  ci = idx[3] ? lo_nib : hi_nib;
      KIND_MID: ci = idx[2] ? lo_nib : hi_nib;
      KIND_TXT32: begin
        // two pixels per font bit, msb first
        bit_on = job.font_row[3'd7 - idx[3:1]] ^ ~job.norm;
        ci     = bit_on ? job.text_color : CI_BLACK;
      end
      KIND_TXT64: begin
        bit_on = job.font_row[3'd6 - idx[2:0]] ^ job.inv;
        ci     = bit_on ? CI_WHITE : CI_BLACK;
      end
      KIND_HI: begin
        bit_on = job.data_byte[3'd7 - idx[3:1]];
        ci     = bit_on ? CI_WHITE : CI_BLACK;
      end
      default: ci = CI_BLACK;
    endcase
  end

  always_comb begin
    result.last = (idx == job.last_idx);
    if (job.kind == KIND_ADDR) begin
      result.pixel_x      = '0;
      result.color_index  = '0;
      result.pixel_rgb    = '0;
      result.cell_address = job.cell_address;
      result.font_address = job.font_address;
    end else begin
      result.pixel_x      = job.x_base + X_W'(idx);
      result.color_index  = ci;
      result.pixel_rgb    = palette_rgb(ci);
      result.cell_address = '0;
      result.font_address = '0;
    end
  end

endmodule

`default_nettype wire

### hdl/video_mode_pixel_generator.sv
// Video mode pixel generator: tick, address query and cell render items in,
// pixel or address results out. Depends on vmpg_pkg and vmpg_pixel.
//
// Usage:
//   in_valid/in_stall/in_item carry commands; out_valid/out_stall/out_item
//   carry results; cfg_we/cfg_index/cfg_data write mode_byte (index 0) and
//   blink_period (index 1) while the block is idle.
//   A tick updates the blink counter at acceptance and gives no result.
//   An accepted query or render is decoded into a job register; its first
//   result is registered from there into the output register, then one
//   result follows per cycle unless out_stall holds it: 1 for a query,
//   16 for low-res and hi-res, 8 for mid-res, 14 for 32-column text, 7 for
//   64-column text. Each cell's results leave through the single result
//   port; the next item is accepted in the cycle the current job moves its
//   last result, so jobs run back to back.
//   Items with no result (tick, undefined mode, column past 31 in the
//   32-cell modes, command three) load no job.
//   While out_stall is high the output register holds its transaction and
//   the job stalls; in_stall stays high while a job is loaded, except in
//   the cycle that moves its last result.
//   Reset clears the blink state, loads the register defaults and empties
//   both stages.
`default_nettype none

module video_mode_pixel_generator
  import vmpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [7:0]       mode_r;
  logic [CNT_W-1:0] period_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             phase_r, phase_nxt;

  job_t             job_r, job_nxt;
  logic             job_v_r, job_v_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  out_item_t        out_r;
  logic             out_v_r, out_v_nxt;

  out_item_t        result;
  logic             job_emit;
  logic             job_done;
  logic             in_acc;
  logic             job_start;
  logic [2:0]       mode_sel;
  logic             col_ok;
  logic [CNT_W:0]   sum;
  logic [CNT_W:0]   rem;
  logic             wrap;
  logic [CA_W-1:0]  bank;
  logic [CA_W-1:0]  page;

  assign job_emit = job_v_r && (!out_v_r || !out_stall);
  assign job_done = job_emit && (idx_r == job_r.last_idx);
  assign in_stall = job_v_r && !job_done;
  assign in_acc   = in_valid && !in_stall;

  assign mode_sel = {mode_r[7], mode_r[1:0]};
  assign col_ok   = !in_item.column[5];
  assign bank     = {mode_r[6:4], 13'd0};
  assign page     = {3'd0, mode_r[3:2], 11'd0};

  // blink counter: add, subtract the period once, saturate
  assign sum  = {1'b0, count_r} + (CNT_W+1)'(in_item.tick_cycles);
  assign wrap = (sum >= {1'b0, period_r});
  assign rem  = wrap ? (sum - {1'b0, period_r}) : sum;

  always_comb begin
    count_nxt = count_r;
    phase_nxt = phase_r;
    if (in_acc && in_item.command == CMD_TICK) begin
      count_nxt = rem[CNT_W] ? '1 : rem[CNT_W-1:0];
      phase_nxt = phase_r ^ wrap;
    end
  end

  // decode an accepted item into a job
  always_comb begin
    job_nxt              = job_r;
    job_start            = 1'b0;
    job_nxt.data_byte    = in_item.data_byte;
    job_nxt.font_row     = in_item.font_row;
    job_nxt.norm         = in_item.attribute_byte[5]
                           | (in_item.attribute_byte[3] & phase_r);
    job_nxt.text_color   = {in_item.attribute_byte[4], in_item.attribute_byte[2:0]};
    job_nxt.inv          = ~mode_r[2];
    job_nxt.font_address = {in_item.data_byte, in_item.line[2:0]};
    job_nxt.cell_address = '0;
    job_nxt.x_base       = '0;
    job_nxt.kind         = KIND_ADDR;
    job_nxt.last_idx     = LAST_ADDR;
    if (in_item.command == CMD_ADDR) begin
      job_start = 1'b1;
      unique case (mode_sel)
        MODE_LO: job_nxt.cell_address = bank + page
          + CA_W'({in_item.line[7:2], 5'd0}) + CA_W'(in_item.column);
        MODE_MID: job_nxt.cell_address = bank
          + CA_W'({in_item.line[7:1], 6'd0}) + CA_W'(in_item.column);
        MODE_TXT32: job_nxt.cell_address = bank + page
          + CA_W'({in_item.line[7:3], 6'd0}) + CA_W'({in_item.column, 1'b0});
        MODE_TXT64: job_nxt.cell_address = bank + page
          + CA_W'({in_item.line[7:3], 6'd0}) + CA_W'(in_item.column);
        MODE_HI: job_nxt.cell_address = bank
          + CA_W'({in_item.line, 5'd0}) + CA_W'(in_item.column);
        default: job_start = 1'b0;
      endcase
    end else if (in_item.command == CMD_RENDER) begin
      unique case (mode_sel)
        MODE_LO: begin
          job_start        = col_ok;
          job_nxt.kind     = KIND_LO;
          job_nxt.last_idx = LAST_LO;
          job_nxt.x_base   = {in_item.column[4:0], 4'd0};
        end
        MODE_MID: begin
          job_start        = 1'b1;
          job_nxt.kind     = KIND_MID;
          job_nxt.last_idx = LAST_MID;
          job_nxt.x_base   = {in_item.column, 3'd0};
        end
        MODE_TXT32: begin
          job_start        = col_ok;
          job_nxt.kind     = KIND_TXT32;
          job_nxt.last_idx = LAST_TXT32;
          job_nxt.x_base   = X_W'(10'd32 + 10'(in_item.column[4:0]) * 10'd14);
        end
        MODE_TXT64: begin
          job_start        = 1'b1;
          job_nxt.kind     = KIND_TXT64;
          job_nxt.last_idx = LAST_TXT64;
          job_nxt.x_base   = X_W'(10'd32 + 10'(in_item.column) * 10'd7);
        end
        MODE_HI: begin
          job_start        = col_ok;
          job_nxt.kind     = KIND_HI;
          job_nxt.last_idx = LAST_HI;
          job_nxt.x_base   = {in_item.column[4:0], 4'd0};
        end
        default: job_start = 1'b0;
      endcase
    end
  end

  always_comb begin
    job_v_nxt = job_v_r;
    idx_nxt   = idx_r;
    if (job_done) begin
      job_v_nxt = 1'b0;
    end else if (job_emit) begin
      idx_nxt = idx_r + 1'b1;
    end
    // load a new job after the old one drains
    if (in_acc && job_start) begin
      job_v_nxt = 1'b1;
      idx_nxt   = '0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (job_emit) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  vmpg_pixel u_pixel (
    .job    (job_r),
    .idx    (idx_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RESET;
      period_r <= PERIOD_RESET;
      count_r  <= '0;
      phase_r  <= 1'b0;
      job_v_r  <= 1'b0;
      idx_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_MODE) begin
        mode_r <= cfg_data[7:0];
      end
      if (cfg_we && cfg_index == REG_PERIOD) begin
        period_r <= cfg_data;
      end
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      job_v_r <= job_v_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && job_start) begin
      job_r <= job_nxt;
    end
    if (job_emit) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

### verif/video_mode_pixel_generator_tb.sv
// Testbench for video_mode_pixel_generator: drives tick, address and render
// transactions with random gaps and output stalls, predicts every pixel and
// address result and checks each one field by field. Depends on vmpg_pkg.
module video_mode_pixel_generator_tb;
  import vmpg_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MAX_PRINTS    = 100;
  localparam int unsigned PHASE_ITEMS   = 5;
  localparam int unsigned PHASE_RAW_MAX = 8;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [7:0] MB_LO    = 8'h00;
  localparam logic [7:0] MB_MID   = 8'h01;
  localparam logic [7:0] MB_TXT32 = 8'h02;
  localparam logic [7:0] MB_HI    = 8'h03;
  localparam logic [7:0] MB_TXT64 = 8'h82;
  localparam logic [7:0] MB_UNDEF = 8'h83;
  // bank 7 and page 3 on top of any mode
  localparam logic [7:0] MB_TOP_BANK_PAGE = 8'h7C;
  localparam logic [7:0] MB_TXT64_PLAIN   = 8'h86;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  // predicted block state
  logic [7:0]  mode_q;
  logic [31:0] period_q;
  logic [31:0] blink_cnt;
  logic        blink_ph;

  out_item_t   pending_results[$];
  out_item_t   want;

  int unsigned burst_left   = 0;
  int unsigned item_results = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_run    = 0;
  int unsigned stall_pct    = 0;

  video_mode_pixel_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: runs of no stall, light stall and heavy stall
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(4, 40);
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        default: stall_pct <= 70;
      endcase
    end else begin
      stall_run <= stall_run - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $time, what, want_v, got_v);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, pixel_x", 32'd0, out_item.pixel_x);
      end else begin
        want = pending_results.pop_front();
        if (out_item.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", want.pixel_x, out_item.pixel_x);
        if (out_item.color_index !== want.color_index)
          report_mismatch("color_index", want.color_index, out_item.color_index);
        if (out_item.pixel_rgb !== want.pixel_rgb)
          report_mismatch("pixel_rgb", want.pixel_rgb, out_item.pixel_rgb);
        if (out_item.cell_address !== want.cell_address)
          report_mismatch("cell_address", want.cell_address, out_item.cell_address);
        if (out_item.font_address !== want.font_address)
          report_mismatch("font_address", want.font_address, out_item.font_address);
        if (out_item.last !== want.last)
          report_mismatch("last", want.last, out_item.last);
      end
    end
  end

  // end the run once no transaction has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [RGB_W-1:0] rgb_of(input logic [CI_W-1:0] ci);
    logic [RGB_W-1:0] rgb;
    case (ci)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hD90000;
      4'd2:    rgb = 24'h00D900;
      4'd3:    rgb = 24'hD9D900;
      4'd4:    rgb = 24'h0000D9;
      4'd5:    rgb = 24'hD900D9;
      4'd6:    rgb = 24'h00D9D9;
      4'd7:    rgb = 24'hD9D9D9;
      4'd8:    rgb = 24'h262626;
      4'd9:    rgb = 24'hFF2626;
      4'd10:   rgb = 24'h26FF26;
      4'd11:   rgb = 24'hFFFF26;
      4'd12:   rgb = 24'h2626FF;
      4'd13:   rgb = 24'hFF26FF;
      4'd14:   rgb = 24'h26FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  function automatic void add_result(input logic [X_W-1:0] x, input logic [CI_W-1:0] ci,
                                     input logic [CA_W-1:0] ca, input logic [FA_W-1:0] fa);
    out_item_t r;
    r.pixel_x      = x;
    r.color_index  = ci;
    r.pixel_rgb    = rgb_of(ci);
    r.cell_address = ca;
    r.font_address = fa;
    r.last         = 1'b0;
    pending_results.push_back(r);
  endfunction

  // apply one accepted transaction to the predicted state and queue its results
  function automatic int unsigned predict_item(input in_item_t it);
    logic [2:0]      msel;
    int unsigned     bank;
    int unsigned     page;
    int unsigned     line;
    int unsigned     col;
    int unsigned     ca;
    int unsigned     prior_n;
    logic [32:0]     sum;
    logic [CI_W-1:0] tcolor;
    logic            norm;
    logic            inv;
    logic            on;
    logic            addr_ok;
    out_item_t       r;
    msel    = {mode_q[7], mode_q[1:0]};
    bank    = 32'(mode_q[6:4]) * 8192;
    page    = 32'(mode_q[3:2]) * 2048;
    line    = it.line;
    col     = it.column;
    prior_n = pending_results.size();
    addr_ok = 1'b1;
    ca      = 0;
    case (it.command)
      CMD_TICK: begin
        sum = {1'b0, blink_cnt} + it.tick_cycles;
        if (sum >= {1'b0, period_q}) begin
          sum      = sum - period_q;
          blink_ph = ~blink_ph;
        end
        blink_cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      CMD_ADDR: begin
        case (msel)
          MODE_LO:    ca = bank + page + (line / 4) * 32 + col;
          MODE_MID:   ca = bank + (line / 2) * 64 + col;
          MODE_TXT32: ca = bank + page + (line / 8) * 64 + col * 2;
          MODE_TXT64: ca = bank + page + (line / 8) * 64 + col;
          MODE_HI:    ca = bank + line * 32 + col;
          default:    addr_ok = 1'b0;
        endcase
        if (addr_ok) begin
          add_result('0, CI_BLACK, ca[15:0], {it.data_byte, it.line[2:0]});
        end
      end
      CMD_RENDER: begin
        case (msel)
          MODE_LO: begin
            if (col < 32) begin
              for (int k = 0; k < 16; k++) begin
                add_result(9'(col * 16 + k), (k < 8) ? it.data_byte[7:4] : it.data_byte[3:0],
                           '0, '0);
              end
            end
          end
          MODE_MID: begin
            for (int k = 0; k < 8; k++) begin
              add_result(9'(col * 8 + k), (k < 4) ? it.data_byte[7:4] : it.data_byte[3:0],
                         '0, '0);
            end
          end
          MODE_TXT32: begin
            if (col < 32) begin
              tcolor = {it.attribute_byte[4], it.attribute_byte[2:0]};
              norm   = it.attribute_byte[5] | (it.attribute_byte[3] & blink_ph);
              for (int k = 7; k >= 1; k--) begin
                on = it.font_row[k] ^ ~norm;
                add_result(9'(32 + col * 14 + (7 - k) * 2), on ? tcolor : CI_BLACK, '0, '0);
                add_result(9'(33 + col * 14 + (7 - k) * 2), on ? tcolor : CI_BLACK, '0, '0);
              end
            end
          end
          MODE_TXT64: begin
            inv = ~mode_q[2];
            for (int b = 6; b >= 0; b--) begin
              on = it.font_row[b] ^ inv;
              add_result(9'(32 + col * 7 + (6 - b)), on ? CI_WHITE : CI_BLACK, '0, '0);
            end
          end
          MODE_HI: begin
            if (col < 32) begin
              for (int b = 7; b >= 0; b--) begin
                add_result(9'(col * 16 + (7 - b) * 2),
                           it.data_byte[b] ? CI_WHITE : CI_BLACK, '0, '0);
                add_result(9'(col * 16 + (7 - b) * 2 + 1),
                           it.data_byte[b] ? CI_WHITE : CI_BLACK, '0, '0);
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (pending_results.size() > prior_n) begin
      r      = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
    return pending_results.size() - prior_n;
  endfunction

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd, input logic [15:0] cyc,
                                         input logic [7:0] line, input logic [5:0] col,
                                         input logic [7:0] data, input logic [7:0] attr,
                                         input logic [7:0] font);
    in_item_t it;
    it.command        = cmd;
    it.tick_cycles    = cyc;
    it.line           = line;
    it.column         = col;
    it.data_byte      = data;
    it.attribute_byte = attr;
    it.font_row       = font;
    return it;
  endfunction

  function automatic logic [7:0] mode_code(input int unsigned i);
    case (i)
      0:       mode_code = MB_LO;
      1:       mode_code = MB_MID;
      2:       mode_code = MB_TXT32;
      3:       mode_code = MB_TXT64;
      default: mode_code = MB_HI;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    item_results = predict_item(it);
  endtask

  // drop valid, let every pending result drain, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_MODE) begin
      mode_q = value[7:0];
    end else begin
      period_q = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic change_mode(input logic [7:0] m);
    wait_idle();
    write_reg(REG_MODE, {24'd0, m});
  endtask

  task automatic test_address_query();
    // reset mode first, before any register write
    send_item(make_item(CMD_ADDR, 16'd0, 8'd13, 6'd5, 8'hA5, 8'd0, 8'd0));
    for (int i = 0; i < 5; i++) begin
      change_mode(mode_code(i));
      send_item(make_item(CMD_ADDR, 16'd0, 8'd0, 6'd0, 8'h00, 8'd0, 8'd0));
      send_item(make_item(CMD_ADDR, 16'hFFFF, 8'd255, 6'd63, 8'hFF, 8'hFF, 8'hFF));
      // top bank and page: the cell address wraps in the low-res, hi-res and 32-column text modes
      change_mode(mode_code(i) | MB_TOP_BANK_PAGE);
      send_item(make_item(CMD_ADDR, 16'd0, 8'd255, 6'd63, 8'h5A, 8'd0, 8'd0));
    end
    change_mode(MB_UNDEF);
    send_item(make_item(CMD_ADDR, 16'd0, 8'd40, 6'd3, 8'h11, 8'd0, 8'd0));
  endtask

  task automatic test_render_cells();
    for (int i = 0; i < 5; i++) begin
      change_mode(mode_code(i));
      send_item(make_item(CMD_RENDER, 16'd0, 8'd0, 6'd0, 8'h1E, 8'h25, 8'h81));
      send_item(make_item(CMD_RENDER, 16'd0, 8'd7, 6'd31, 8'hE1, 8'h1A, 8'h7E));
      // past the last cell of the 32-cell modes
      send_item(make_item(CMD_RENDER, 16'd0, 8'd9, 6'd32, 8'hFF, 8'hFF, 8'h00));
      send_item(make_item(CMD_RENDER, 16'd0, 8'd255, 6'd63, 8'h00, 8'hDF, 8'hFF));
    end
    change_mode(MB_TXT64_PLAIN);
    send_item(make_item(CMD_RENDER, 16'd0, 8'd3, 6'd17, 8'h00, 8'h00, 8'hC6));
    send_item(make_item(CMD_UNUSED, 16'hFFFF, 8'd3, 6'd17, 8'h00, 8'h00, 8'hC6));
    change_mode(MB_UNDEF);
    send_item(make_item(CMD_RENDER, 16'd0, 8'd3, 6'd2, 8'hAA, 8'h3F, 8'hAA));
  endtask

  task automatic test_blink_phase();
    change_mode(MB_TXT32);
    write_reg(REG_PERIOD, 32'd10);
    for (int i = 0; i < 5; i++) begin
      send_item(make_item(CMD_TICK, 16'd4, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_item(CMD_RENDER, 16'd0, 8'd1, 6'(i), 8'd0, 8'h0B, 8'hC3));
    end
    send_item(make_item(CMD_TICK, 16'hFFFF, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd1, 6'd9, 8'd0, 8'h1F, 8'h3C));
    wait_idle();
    write_reg(REG_PERIOD, 32'd1);
    send_item(make_item(CMD_TICK, 16'd0, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd1, 6'd4, 8'd0, 8'h0E, 8'h55));
    // zero period: every tick flips the phase
    wait_idle();
    write_reg(REG_PERIOD, 32'd0);
    send_item(make_item(CMD_TICK, 16'd0, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd1, 6'd6, 8'd0, 8'h0E, 8'h55));
    send_item(make_item(CMD_TICK, 16'd77, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd1, 6'd7, 8'd0, 8'h0E, 8'h55));
  endtask

  // build a count of several periods, then each tick subtracts the period only once
  task automatic test_counter_large();
    change_mode(MB_TXT32);
    write_reg(REG_PERIOD, 32'd0);
    burst_left = 4;
    repeat (4) send_item(make_item(CMD_TICK, 16'hFFFF, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    wait_idle();
    write_reg(REG_PERIOD, 32'h0001_0000);
    send_item(make_item(CMD_TICK, 16'd0, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd2, 6'd1, 8'd0, 8'h0C, 8'h0F));
    send_item(make_item(CMD_TICK, 16'd1, 8'd0, 6'd0, 8'd0, 8'd0, 8'd0));
    send_item(make_item(CMD_RENDER, 16'd0, 8'd2, 6'd2, 8'd0, 8'h0C, 8'h0F));
  endtask

  task automatic test_random_traffic();
    logic [7:0]  m;
    logic [31:0] period;
    int unsigned counted;
    int unsigned raw;
    int unsigned pick;
    in_item_t    it;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: m = 8'h00;
        1: m = 8'hFF;
        2: m = 8'($urandom);
        default: begin
          m      = mode_code($urandom_range(0, 4));
          m[6:2] = 5'($urandom);
        end
      endcase
      case ($urandom_range(0, 3))
        0:       period = 32'd1;
        1:       period = $urandom_range(1, 300000);
        2:       period = 32'hFFFF_FFFF;
        default: period = $urandom;
      endcase
      change_mode(m);
      write_reg(REG_PERIOD, period);
      counted = 0;
      raw     = 0;
      while (counted < PHASE_ITEMS && raw < PHASE_RAW_MAX) begin
        it   = make_item(CMD_RENDER, 16'($urandom), 8'($urandom), 6'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
          it.command = CMD_TICK;
        end else if (pick < 9) begin
          it.command = CMD_ADDR;
        end else if (pick == 19) begin
          it.command = CMD_UNUSED;
        end
        // favor columns that the 32-cell modes render
        if ($urandom_range(0, 9) < 7) it.column[5] = 1'b0;
        send_item(it);
        raw++;
        if (it.command == CMD_TICK || item_results != 0) counted++;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = 32'd0;
    mode_q    = MODE_RESET;
    period_q  = PERIOD_RESET;
    blink_cnt = '0;
    blink_ph  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_address_query();
    test_render_cells();
    test_blink_phase();
    test_counter_large();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
